### rtl/core/tpq_pkg.sv
// Shared types, codes and defaults of the triage priority queue.
package tpq_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int TAG_BITS_DEF = 16;

   localparam int RISK_W = 7;
   localparam int REF_W  = 4;
   localparam int TAG_W  = 16;
   localparam int OCC_W  = 6;

   localparam logic [RISK_W-1:0] MAX_RISK     = 7'd100;
   localparam logic [REF_W-1:0]  MAX_REFERRAL = 4'd10;

   typedef enum logic [1:0] {
      OP_INSERT      = 2'd0,
      OP_SERVE_HEAD  = 2'd1,
      OP_SERVE_REF   = 2'd2,
      OP_SERVE_MATCH = 2'd3
   } tpq_op_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_SERVED   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_NOMATCH  = 3'd3,
      ST_FULL     = 3'd4
   } tpq_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_READ,
      S_INS_CMP,
      S_SCAN_READ,
      S_SCAN_CMP,
      S_SHIFT_READ,
      S_SHIFT_WRITE,
      S_RESPOND
   } tpq_state_type;

   typedef struct packed {
      tpq_op_type          req_type;
      logic [RISK_W-1:0]   risk_level;
      logic [REF_W-1:0]    referral_level;
      logic [TAG_W-1:0]    patient_tag;
   } tpq_req_type;

   typedef struct packed {
      tpq_status_type      status;
      logic [TAG_W-1:0]    served_tag;
      logic [RISK_W-1:0]   served_risk;
      logic [REF_W-1:0]    served_referral;
      logic [OCC_W-1:0]    occupancy;
   } tpq_rsp_type;

   typedef struct packed {
      logic risk_ge;
      logic ref_gt;
      logic ref_eq;
   } tpq_cmp_type;

endpackage

### rtl/core/tpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tpq_cmp.sv
// Shared compare unit: checks one stored entry against the request key and the best so far.
module tpq_cmp (
   input  logic [tpq_pkg::RISK_W-1:0] entry_risk,
   input  logic [tpq_pkg::REF_W-1:0]  entry_referral,
   input  logic [tpq_pkg::RISK_W-1:0] key_risk,
   input  logic [tpq_pkg::REF_W-1:0]  key_referral,
   input  logic [tpq_pkg::REF_W-1:0]  best_referral,
   output tpq_pkg::tpq_cmp_type       flags
);

   import tpq_pkg::*;

   always_comb begin
      flags.risk_ge = (entry_risk >= key_risk);
      flags.ref_gt  = (entry_referral > best_referral);
      flags.ref_eq  = (entry_referral == key_referral);
   end

endmodule

### rtl/core/triage_priority_queue_core.sv
// Top level of the triage priority queue: sequencer, sorted entry RAM and compare unit.
//
// Requests enter on the req_ channel (valid/ready) and each one produces exactly one
// item on the rsp_ channel. The queue holds up to CAPACITY entries in descending risk
// order, ties in arrival order, in a single-port-write RAM with registered read.
// One request is processed at a time by a sequencer that drives one compare unit.
// An insert walks from the tail toward the head, moving each lower-risk entry down one
// slot. A serve scans from the head, comparing each entry visited, then closes the gap
// by moving each later entry up one slot. A rejected insert or a serve of an empty
// queue goes straight to the response step. req_ready returns the cycle after the
// response is loaded, so a new request is taken only once the last one is finished.
// The response sits in an output register, so req_ready returns while an earlier
// response still waits for rsp_ready; the sequencer only stalls at its last step
// when that register is still full. Reset empties the queue at once; the RAM
// contents are not cleared because only held entries are ever read.
module triage_priority_queue_core #(
   parameter int CAPACITY = tpq_pkg::CAPACITY_DEF,
   parameter int TAG_BITS = tpq_pkg::TAG_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tpq_pkg::tpq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tpq_pkg::tpq_rsp_type rsp_data
);

   import tpq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int TW    = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
   localparam int ENT_W = TW + RISK_W + REF_W;

   tpq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   tpq_op_type        op_ff, op_in;
   logic [TW-1:0]     key_tag_ff, key_tag_in;
   logic [RISK_W-1:0] key_risk_ff, key_risk_in;
   logic [REF_W-1:0]  key_ref_ff, key_ref_in;
   logic [ENT_W-1:0]  best_ff, best_in;
   tpq_status_type    status_ff, status_in;
   tpq_rsp_type       rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [ENT_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [ENT_W-1:0]  ram_rd_data;

   tpq_cmp_type       cmp;
   logic              req_fire;
   logic              full;
   logic              at_last;
   logic              upd;
   logic              take;
   logic              slot_free;
   logic [IDX_W-1:0]  last_idx;
   logic [ENT_W-1:0]  new_entry;

   tpq_ram #(
      .WIDTH(ENT_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   tpq_cmp u_cmp (
      .entry_risk    (ram_rd_data[REF_W +: RISK_W]),
      .entry_referral(ram_rd_data[REF_W-1:0]),
      .key_risk      (key_risk_ff),
      .key_referral  (key_ref_ff),
      .best_referral (best_ff[REF_W-1:0]),
      .flags         (cmp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign at_last   = (idx_ff == last_idx);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign new_entry = {key_tag_ff, key_risk_ff, key_ref_ff};

   always_comb begin
      upd  = 1'b0;
      take = 1'b0;
      unique case (op_ff)
         OP_SERVE_HEAD: begin
            upd  = 1'b1;
            take = 1'b1;
         end
         OP_SERVE_REF: begin
            upd  = (idx_ff == '0) || cmp.ref_gt;
            take = at_last;
         end
         OP_SERVE_MATCH: begin
            upd  = cmp.ref_eq;
            take = cmp.ref_eq;
         end
         default: begin
            upd  = 1'b0;
            take = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.req_type == OP_INSERT) begin
                  state_in = full ? S_RESPOND : S_INS_READ;
               end else begin
                  state_in = (count_ff == '0) ? S_RESPOND : S_SCAN_READ;
               end
            end
         end
         S_INS_READ:    state_in = (idx_ff == '0) ? S_RESPOND : S_INS_CMP;
         S_INS_CMP:     state_in = cmp.risk_ge ? S_RESPOND : S_INS_READ;
         S_SCAN_READ:   state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (take) begin
               state_in = S_SHIFT_READ;
            end else if (at_last) begin
               state_in = S_RESPOND;
            end else begin
               state_in = S_SCAN_READ;
            end
         end
         S_SHIFT_READ:  state_in = at_last ? S_RESPOND : S_SHIFT_WRITE;
         S_SHIFT_WRITE: state_in = S_SHIFT_READ;
         S_RESPOND:     state_in = slot_free ? S_IDLE : S_RESPOND;
         default:       state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      op_in        = op_ff;
      key_tag_in   = key_tag_ff;
      key_risk_in  = key_risk_ff;
      key_ref_in   = key_ref_ff;
      best_in      = best_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = new_entry;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in       = req_data.req_type;
               key_tag_in  = req_data.patient_tag[TW-1:0];
               key_risk_in = (req_data.risk_level > MAX_RISK) ? MAX_RISK
                                                               : req_data.risk_level;
               key_ref_in  = req_data.referral_level;
               if (req_data.req_type == OP_INSERT) begin
                  if (req_data.referral_level > MAX_REFERRAL) begin
                     key_ref_in = MAX_REFERRAL;
                  end
                  idx_in    = IDX_W'(count_ff);
                  status_in = full ? ST_FULL : ST_INSERTED;
               end else begin
                  idx_in    = '0;
                  status_in = (count_ff == '0) ? ST_EMPTY : ST_NOMATCH;
               end
            end
         end
         S_INS_READ: begin
            if (idx_ff == '0) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff - IDX_W'(1);
            end
         end
         S_INS_CMP: begin
            ram_wr_en = 1'b1;
            if (cmp.risk_ge) begin
               count_in = count_ff + CNT_W'(1);
            end else begin
               ram_wr_data = ram_rd_data;
               idx_in      = idx_ff - IDX_W'(1);
            end
         end
         S_SCAN_READ: begin
            ram_rd_en = 1'b1;
         end
         S_SCAN_CMP: begin
            if (upd) begin
               best_in = ram_rd_data;
               pos_in  = idx_ff;
            end
            if (take) begin
               status_in = ST_SERVED;
               idx_in    = upd ? idx_ff : pos_ff;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_SHIFT_READ: begin
            if (at_last) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + IDX_W'(1);
            end
         end
         S_SHIFT_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
            idx_in      = idx_ff + IDX_W'(1);
         end
         S_RESPOND: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = status_ff;
               rsp_in.occupancy = OCC_W'(count_ff);
               if (status_ff == ST_SERVED) begin
                  rsp_in.served_tag      = TAG_W'(best_ff[ENT_W-1 -: TW]);
                  rsp_in.served_risk     = best_ff[REF_W +: RISK_W];
                  rsp_in.served_referral = best_ff[REF_W-1:0];
               end else begin
                  rsp_in.served_tag      = '0;
                  rsp_in.served_risk     = '0;
                  rsp_in.served_referral = '0;
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      op_ff       <= op_in;
      key_tag_ff  <= key_tag_in;
      key_risk_ff <= key_risk_in;
      key_ref_ff  <= key_ref_in;
      best_ff     <= best_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("Entry count exceeds capacity.");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (CNT_W'(ram_wr_addr) <= count_ff))
      else $error("Store write lands beyond the held entries.");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("Sequencer did not start on an accepted item.");

   a_count_change_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ($past(state_ff) == S_INS_READ || $past(state_ff) == S_INS_CMP ||
          $past(state_ff) == S_SHIFT_READ))
      else $error("Entry count changed outside an insert or removal step.");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the triage priority queue core, with a mirror of its sorted queue.
module tb;
   import tpq_pkg::*;

   localparam int DEPTH = CAPACITY_DEF;

   class queue_mirror;
      logic [TAG_W-1:0]  held_tag [DEPTH];
      logic [RISK_W-1:0] held_risk [DEPTH];
      logic [REF_W-1:0]  held_ref [DEPTH];
      int                held_count;
      tpq_rsp_type       awaited [$];
      int                errors;

      function new();
         held_count = 0;
         errors = 0;
      endfunction

      function void note_request(tpq_req_type req);
         tpq_rsp_type       rsp;
         logic [RISK_W-1:0] risk;
         logic [REF_W-1:0]  refl;
         int                pos;
         int                i;
         rsp = '0;
         pos = -1;
         if (req.req_type == OP_INSERT) begin
            if (held_count >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               risk = (req.risk_level > MAX_RISK) ? MAX_RISK : req.risk_level;
               refl = (req.referral_level > MAX_REFERRAL) ? MAX_REFERRAL : req.referral_level;
               pos = 0;
               while (pos < held_count && held_risk[pos] >= risk)
                  pos++;
               for (i = held_count; i > pos; i--) begin
                  held_tag[i] = held_tag[i-1];
                  held_risk[i] = held_risk[i-1];
                  held_ref[i] = held_ref[i-1];
               end
               held_tag[pos] = req.patient_tag;
               held_risk[pos] = risk;
               held_ref[pos] = refl;
               held_count++;
               rsp.status = ST_INSERTED;
            end
         end else if (held_count == 0) begin
            rsp.status = ST_EMPTY;
         end else begin
            case (req.req_type)
               OP_SERVE_HEAD: begin
                  pos = 0;
               end
               OP_SERVE_REF: begin
                  pos = 0;
                  for (i = 1; i < held_count; i++)
                     if (held_ref[i] > held_ref[pos])
                        pos = i;
               end
               default: begin
                  for (i = 0; i < held_count && pos < 0; i++)
                     if (held_ref[i] == req.referral_level)
                        pos = i;
               end
            endcase
            if (pos < 0) begin
               rsp.status = ST_NOMATCH;
            end else begin
               rsp.status = ST_SERVED;
               rsp.served_tag = held_tag[pos];
               rsp.served_risk = held_risk[pos];
               rsp.served_referral = held_ref[pos];
               for (i = pos; i < held_count - 1; i++) begin
                  held_tag[i] = held_tag[i+1];
                  held_risk[i] = held_risk[i+1];
                  held_ref[i] = held_ref[i+1];
               end
               held_count--;
            end
         end
         rsp.occupancy = OCC_W'(held_count);
         awaited.push_back(rsp);
      endfunction

      function void check_response(tpq_rsp_type got);
         tpq_rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response with none awaited, actual %h", $time, got);
            errors++;
         end else begin
            want = awaited.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
               errors++;
            end
            if (got.served_tag !== want.served_tag) begin
               $display("%0t: served_tag expected %h actual %h", $time,
                        want.served_tag, got.served_tag);
               errors++;
            end
            if (got.served_risk !== want.served_risk) begin
               $display("%0t: served_risk expected %0d actual %0d", $time,
                        want.served_risk, got.served_risk);
               errors++;
            end
            if (got.served_referral !== want.served_referral) begin
               $display("%0t: served_referral expected %0d actual %0d", $time,
                        want.served_referral, got.served_referral);
               errors++;
            end
            if (got.occupancy !== want.occupancy) begin
               $display("%0t: occupancy expected %0d actual %0d", $time,
                        want.occupancy, got.occupancy);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   tpq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   tpq_rsp_type rsp_data;

   int tx_idle_pct = 27;
   int rx_idle_pct = 83;
   int idle_stage = 0;

   queue_mirror book = new();

   triage_priority_queue_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic tpq_req_type make_req(tpq_op_type op, logic [RISK_W-1:0] risk,
                                            logic [REF_W-1:0] refl, logic [TAG_W-1:0] tag);
      tpq_req_type req;
      req.req_type = op;
      req.risk_level = risk;
      req.referral_level = refl;
      req.patient_tag = tag;
      return req;
   endfunction

   task automatic send_request(tpq_req_type req);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= req;
      do
         @(posedge clock);
      while (!req_ready);
      book.note_request(req);
      @(negedge clock);
   endtask

   task automatic random_block(int count, int insert_pct);
      tpq_op_type        op;
      logic [RISK_W-1:0] risk;
      logic [REF_W-1:0]  refl;
      repeat (count) begin
         if ($urandom_range(99) < insert_pct)
            op = OP_INSERT;
         else
            op = tpq_op_type'($urandom_range(3, 1));
         if ($urandom_range(1) == 0)
            risk = RISK_W'($urandom_range(4) * 25);
         else
            risk = RISK_W'($urandom_range(127));
         if ($urandom_range(9) == 0)
            refl = REF_W'($urandom_range(15));
         else
            refl = REF_W'($urandom_range(10));
         send_request(make_req(op, risk, refl, TAG_W'($urandom_range(65535))));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_response(rsp_data);
   end

   initial begin : receiver
      int hold_left;
      bit held_off;
      hold_left = 0;
      held_off = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (idle_stage == 2 && !held_off) begin
            held_off = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin : stimulus
      int insert_mix [10];
      insert_mix = '{90, 95, 50, 30, 10, 60, 95, 40, 15, 55};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(make_req(OP_SERVE_HEAD, 7'd127, 4'd15, 16'hFFFF));
      send_request(make_req(OP_SERVE_REF, 7'd0, 4'd0, 16'h0000));
      send_request(make_req(OP_SERVE_MATCH, 7'd55, 4'd3, 16'h5A5A));
      send_request(make_req(OP_INSERT, 7'd0, 4'd0, 16'h0000));
      send_request(make_req(OP_INSERT, 7'd100, 4'd10, 16'hFFFF));
      send_request(make_req(OP_INSERT, 7'd127, 4'd15, 16'h1234));
      send_request(make_req(OP_INSERT, 7'd101, 4'd11, 16'h8001));
      send_request(make_req(OP_INSERT, 7'd100, 4'd3, 16'h00AA));
      send_request(make_req(OP_INSERT, 7'd50, 4'd10, 16'h0055));
      send_request(make_req(OP_INSERT, 7'd50, 4'd7, 16'h7777));
      send_request(make_req(OP_INSERT, 7'd0, 4'd7, 16'h7FFF));
      send_request(make_req(OP_SERVE_MATCH, 7'd0, 4'd12, 16'h0000));
      send_request(make_req(OP_SERVE_MATCH, 7'd0, 4'd5, 16'h0000));
      send_request(make_req(OP_SERVE_MATCH, 7'd0, 4'd7, 16'h0000));
      send_request(make_req(OP_SERVE_REF, 7'd0, 4'd0, 16'h0000));
      send_request(make_req(OP_SERVE_HEAD, 7'd0, 4'd0, 16'h0000));
      send_request(make_req(OP_SERVE_MATCH, 7'd0, 4'd0, 16'h0000));
      send_request(make_req(OP_SERVE_REF, 7'd0, 4'd0, 16'h0000));
      send_request(make_req(OP_SERVE_HEAD, 7'd0, 4'd0, 16'h0000));
      send_request(make_req(OP_SERVE_HEAD, 7'd0, 4'd0, 16'h0000));
      send_request(make_req(OP_SERVE_HEAD, 7'd0, 4'd0, 16'h0000));
      send_request(make_req(OP_SERVE_MATCH, 7'd0, 4'd10, 16'h0000));

      for (int s = 0; s < 3; s++) begin
         idle_stage = s;
         tx_idle_pct = (s == 0) ? 27 : (s == 1) ? 83 : 0;
         rx_idle_pct = (s == 0) ? 83 : (s == 1) ? 27 : 0;
         for (int b = 0; b < 10; b++)
            random_block(41, insert_mix[b]);
      end
      req_valid <= 1'b0;

      while (book.awaited.size() != 0)
         @(posedge clock);
      repeat (140) @(posedge clock);
      if (book.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule
